@@ rtl/bmec_pkg.sv @@
// ----------------------------------------------------------------------------
// bmec_pkg: shared types and constants of the block map extent coalescer
// Region and error codes, the classification record and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package bmec_pkg;

  localparam int DIRECT_BLOCKS_DEF = 12;
  localparam int IDX_W             = 32;
  localparam int BLK_W             = 32;
  localparam int LEN_W             = 15;
  localparam int LOG_W             = 3;
  localparam int SECT_W            = 39;
  localparam int CNT_W             = 22;
  localparam int OFF_W             = 32;
  localparam int MAX_LOG           = 6;
  // result queue depth, power of two so the pointers wrap by themselves
  localparam int RES_DEPTH         = 4;
  localparam int RES_PTR_W         = $clog2(RES_DEPTH);
  localparam int RES_CNT_W         = $clog2(RES_DEPTH + 1);

  typedef enum logic [1:0] {
    REGION_DIRECT = 2'd0,
    REGION_SINGLE = 2'd1,
    REGION_DOUBLE = 2'd2
  } region_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_HOLE  = 2'd1,
    ERR_RANGE = 2'd2
  } err_t;

  typedef struct packed {
    region_t            region;
    err_t               err;
    logic               frame_start;
    logic [LEN_W-1:0]   cap;
  } cls_t;

  typedef struct packed {
    logic [SECT_W-1:0]  start_sector;
    logic [CNT_W-1:0]   sector_count;
    logic [OFF_W-1:0]   buffer_block_offset;
    region_t            region;
    err_t               error;
    logic               last_run;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/bmec_classify.sv @@
// ----------------------------------------------------------------------------
// bmec_classify: logical index classification
// Sorts an index into direct, single or double indirect, finds frame starts,
// the run length cap of the region and the error code of the item.
// ----------------------------------------------------------------------------
`default_nettype none

module bmec_classify #(
  parameter int DIRECT_BLOCKS = bmec_pkg::DIRECT_BLOCKS_DEF
) (
  input  wire logic [bmec_pkg::IDX_W-1:0] logical_index,
  input  wire logic [bmec_pkg::BLK_W-1:0] physical_block,
  input  wire logic [bmec_pkg::LOG_W-1:0] log_eff,
  output bmec_pkg::cls_t                  cls
);
  import bmec_pkg::*;

  logic [LEN_W-1:0] per;
  logic [33:0]      s_range;
  logic [33:0]      dbl_span;
  logic [33:0]      d_range;
  logic [33:0]      idx_ext;
  logic [4:0]       dbl_shift;
  logic [31:0]      frame_off;

  // entries per indirect block: block_size / 4
  assign per       = LEN_W'(16'd256 << log_eff);
  assign s_range   = 34'(DIRECT_BLOCKS) + 34'(per);
  assign dbl_shift = 5'd16 + 5'({log_eff, 1'b0});
  assign dbl_span  = 34'd1 << dbl_shift;
  assign d_range   = s_range + dbl_span;
  assign idx_ext   = 34'(logical_index);
  assign frame_off = logical_index - s_range[31:0];

  always_comb begin
    cls.region      = REGION_DIRECT;
    cls.err         = ERR_NONE;
    cls.frame_start = 1'b0;
    cls.cap         = per;
    if (idx_ext >= d_range) begin
      cls.err         = ERR_RANGE;
      cls.frame_start = 1'b1;
    end else if (idx_ext >= s_range) begin
      cls.region      = REGION_DOUBLE;
      cls.frame_start = (frame_off & (32'(per) - 32'd1)) == 32'd0;
    end else if (logical_index >= 32'(DIRECT_BLOCKS)) begin
      cls.region      = REGION_SINGLE;
      cls.frame_start = logical_index == 32'(DIRECT_BLOCKS);
    end else begin
      cls.cap = LEN_W'(DIRECT_BLOCKS);
    end
    // out of range wins over a hole
    if (cls.err == ERR_NONE && physical_block == '0) begin
      cls.err = ERR_HOLE;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bmec_res_fifo.sv @@
// ----------------------------------------------------------------------------
// bmec_res_fifo: result queue
// Small register queue that takes up to two results a cycle and hands out
// one per transfer on the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module bmec_res_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push0,
  input  wire logic           push1,
  input  wire bmec_pkg::res_t data0,
  input  wire bmec_pkg::res_t data1,
  input  wire logic           pop,
  output logic                out_valid,
  output bmec_pkg::res_t      out_data,
  output logic                room2
);
  import bmec_pkg::*;

  res_t                 mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr;
  logic [RES_PTR_W-1:0] rd_ptr;
  logic [RES_CNT_W-1:0] count;
  logic [RES_PTR_W-1:0] wr_ptr1;
  logic                 do_pop;

  assign out_valid = count != '0;
  assign out_data  = mem[rd_ptr];
  assign room2     = count <= RES_CNT_W'(RES_DEPTH - 2);
  assign do_pop    = pop && out_valid;
  assign wr_ptr1   = wr_ptr + RES_PTR_W'(push0);

  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wr_ptr] <= data0;
    end
    if (push1) begin
      mem[wr_ptr1] <= data1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_PTR_W'(push0) + RES_PTR_W'(push1);
      rd_ptr <= rd_ptr + RES_PTR_W'(do_pop);
      count  <= count + RES_CNT_W'(push0) + RES_CNT_W'(push1) - RES_CNT_W'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= RES_CNT_W'(RES_DEPTH))
    else $error("result queue overflow");

  a_push_order: assert property (@(posedge clk) disable iff (rst)
    push1 && !push0 |-> 1'b0)
    else $error("second result pushed without the first");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push0 || push1) |-> count <= RES_CNT_W'(RES_DEPTH - 2) || !(push0 && push1))
    else $error("double push without room");

endmodule

`default_nettype wire

@@ rtl/block_map_extent_coalescer.sv @@
// ----------------------------------------------------------------------------
// block_map_extent_coalescer: merges block map entries into disk runs
// Classifies logical blocks, coalesces physically consecutive blocks and
// emits runs in 512-byte sectors.
// ----------------------------------------------------------------------------
// One block map entry is taken per cycle while the queue has two free slots.
// Each transfer lands in an input register; once the queue has two free slots
// the entry is classified, compared against the open run and turned into zero,
// one or two results that enter a four-entry result queue, which feeds the
// output. The input side takes a transfer whenever the queue has two free
// slots. The output gives one result per cycle while m_axis_tready is high, so
// entries that each produce two results (a hole right after an open run, or a
// break on the last entry) are paced by the output; merged entries produce
// nothing and flow at one per cycle. log_block_size is to be written by the
// user only while the block is idle, which the block itself does not enforce; a value of 7 acts as 6.
`default_nettype none

module block_map_extent_coalescer #(
  parameter int DIRECT_BLOCKS = bmec_pkg::DIRECT_BLOCKS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wen,
  input  wire logic [2:0]   cfg_wdata,      // log_block_size
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [63:0]  s_axis_tdata,   // logical_index, physical_block
  input  wire logic         s_axis_tlast,   // last_in_request
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [95:0]       m_axis_tdata,   // start_sector, sector_count, buffer_block_offset
  output logic [3:0]        m_axis_tuser,   // region, error
  output logic              m_axis_tlast    // last_run
);
  import bmec_pkg::*;

  logic [LOG_W-1:0] log_block_size;
  logic [LOG_W-1:0] log_eff;
  logic [LOG_W-1:0] spb_shift;

  // input register
  logic             s1_valid;
  logic [IDX_W-1:0] s1_idx;
  logic [BLK_W-1:0] s1_phys;
  logic             s1_last;
  logic             in_xfer;
  logic             go;

  // open run
  logic [BLK_W-1:0] run_start_block, run_start_block_next;
  logic [LEN_W-1:0] run_length, run_length_next;
  logic [OFF_W-1:0] run_buffer_offset, run_buffer_offset_next;
  region_t          run_region, run_region_next;
  logic             run_active, run_active_next;
  logic [OFF_W-1:0] request_progress, request_progress_next;

  cls_t             cls;
  logic             extend;
  logic             push0, push1;
  res_t             res0, res1;
  logic             room2;
  logic             q_valid;
  res_t             q_data;

  function automatic res_t make_run(input logic [BLK_W-1:0] start,
                                    input logic [LEN_W-1:0] len,
                                    input logic [OFF_W-1:0] off,
                                    input region_t          reg_code,
                                    input logic [LOG_W-1:0] shift,
                                    input logic             last);
    res_t r;
    r.start_sector        = SECT_W'({7'd0, start} << shift);
    r.sector_count        = CNT_W'({7'd0, len} << shift);
    r.buffer_block_offset = off;
    r.region              = reg_code;
    r.error               = ERR_NONE;
    r.last_run            = last;
    return r;
  endfunction

  assign log_eff   = (log_block_size > LOG_W'(MAX_LOG)) ? LOG_W'(MAX_LOG) : log_block_size;
  assign spb_shift = log_eff + LOG_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      log_block_size <= '0;
    end else if (cfg_wen) begin
      log_block_size <= cfg_wdata;
    end
  end

  assign go            = s1_valid && room2;
  assign s_axis_tready = !s1_valid || room2;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_idx  <= s_axis_tdata[31:0];
      s1_phys <= s_axis_tdata[63:32];
      s1_last <= s_axis_tlast;
    end
  end

  bmec_classify #(
    .DIRECT_BLOCKS (DIRECT_BLOCKS)
  ) u_classify (
    .logical_index  (s1_idx),
    .physical_block (s1_phys),
    .log_eff        (log_eff),
    .cls            (cls)
  );

  assign extend = run_active && !cls.frame_start && run_region == cls.region &&
                  run_length < cls.cap &&
                  ({1'b0, run_start_block} + 33'(run_length)) == {1'b0, s1_phys};

  always_comb begin
    run_start_block_next   = run_start_block;
    run_length_next        = run_length;
    run_buffer_offset_next = run_buffer_offset;
    run_region_next        = run_region;
    run_active_next        = run_active;
    request_progress_next  = request_progress;
    push0 = 1'b0;
    push1 = 1'b0;
    res0  = make_run(run_start_block, run_length, run_buffer_offset, run_region,
                     spb_shift, 1'b0);
    res1  = res0;
    if (go) begin
      request_progress_next = s1_last ? '0 : request_progress + OFF_W'(1);
      if (cls.err != ERR_NONE) begin
        // close the open run, then report the bad entry
        res1.start_sector        = '0;
        res1.sector_count        = '0;
        res1.buffer_block_offset = request_progress;
        res1.region              = cls.region;
        res1.error               = cls.err;
        res1.last_run            = s1_last;
        run_active_next          = 1'b0;
        if (run_active) begin
          push0 = 1'b1;
          push1 = 1'b1;
        end else begin
          push0 = 1'b1;
          res0  = res1;
        end
      end else if (extend) begin
        run_length_next = run_length + LEN_W'(1);
        if (s1_last) begin
          push0           = 1'b1;
          res0            = make_run(run_start_block, run_length_next, run_buffer_offset,
                                     run_region, spb_shift, 1'b1);
          run_active_next = 1'b0;
        end
      end else begin
        run_start_block_next   = s1_phys;
        run_length_next        = LEN_W'(1);
        run_buffer_offset_next = request_progress;
        run_region_next        = cls.region;
        run_active_next        = !s1_last;
        res1 = make_run(s1_phys, LEN_W'(1), request_progress, cls.region, spb_shift, 1'b1);
        if (run_active) begin
          push0 = 1'b1;
          push1 = s1_last;
        end else if (s1_last) begin
          push0 = 1'b1;
          res0  = res1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_start_block   <= '0;
      run_length        <= '0;
      run_buffer_offset <= '0;
      run_region        <= REGION_DIRECT;
      run_active        <= 1'b0;
      request_progress  <= '0;
    end else begin
      run_start_block   <= run_start_block_next;
      run_length        <= run_length_next;
      run_buffer_offset <= run_buffer_offset_next;
      run_region        <= run_region_next;
      run_active        <= run_active_next;
      request_progress  <= request_progress_next;
    end
  end

  bmec_res_fifo u_res_fifo (
    .clk       (clk),
    .rst       (rst),
    .push0     (push0),
    .push1     (push1),
    .data0     (res0),
    .data1     (res1),
    .pop       (m_axis_tready),
    .out_valid (q_valid),
    .out_data  (q_data),
    .room2     (room2)
  );

  assign m_axis_tvalid = q_valid;
  assign m_axis_tdata  = {3'd0, q_data.buffer_block_offset, q_data.sector_count,
                          q_data.start_sector};
  assign m_axis_tuser  = {q_data.error, q_data.region};
  assign m_axis_tlast  = q_data.last_run;

  a_run_nonempty: assert property (@(posedge clk) disable iff (rst)
    run_active |-> run_length != '0)
    else $error("open run with zero length");

  a_run_bounded: assert property (@(posedge clk) disable iff (rst)
    run_active |-> run_length <= (LEN_W'(256) << MAX_LOG))
    else $error("run longer than an indirect block");

  a_request_end: assert property (@(posedge clk) disable iff (rst)
    go && s1_last |=> !run_active && request_progress == '0)
    else $error("run left open after end of request");

  a_error_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && q_data.error != ERR_NONE |->
      q_data.sector_count == '0 && q_data.start_sector == '0)
    else $error("error result carries sectors");

endmodule

`default_nettype wire
